/* design/bencode_info_value_locator_assert.svh */
// Assertion macros shared by the locator RTL.
`ifndef BENCODE_INFO_VALUE_LOCATOR_ASSERT_SVH
`define BENCODE_INFO_VALUE_LOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BIVL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BIVL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bivl_pkg.sv */
package bivl_pkg;

  // Widths of the scan counters
  localparam int OFFSET_BITS = 32;
  localparam int DEPTH_BITS  = 16;
  localparam int CNT_BITS    = OFFSET_BITS + 1;
  localparam int FIELD_BITS  = 32;

  // Bencode syntax bytes
  localparam logic [7:0] CHR_D     = 8'h64;  // 'd'
  localparam logic [7:0] CHR_E     = 8'h65;  // 'e'
  localparam logic [7:0] CHR_I     = 8'h69;  // 'i'
  localparam logic [7:0] CHR_L     = 8'h6c;  // 'l'
  localparam logic [7:0] CHR_COLON = 8'h3a;  // ':'
  localparam logic [7:0] CHR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHR_NINE  = 8'h39;  // '9'

  // Target key is "info"
  localparam logic [CNT_BITS-1:0] KEY_LEN = CNT_BITS'(4);

  typedef enum logic [9:0] {
    PH_OPEN     = 10'b00_0000_0001,
    PH_ENTRY    = 10'b00_0000_0010,
    PH_KEYLEN   = 10'b00_0000_0100,
    PH_KEYBODY  = 10'b00_0000_1000,
    PH_VALSTART = 10'b00_0001_0000,
    PH_INT      = 10'b00_0010_0000,
    PH_STRLEN   = 10'b00_0100_0000,
    PH_STRBODY  = 10'b00_1000_0000,
    PH_NEST     = 10'b01_0000_0000,
    PH_DONE     = 10'b10_0000_0000
  } scan_phase_t;

  typedef enum logic [3:0] {
    IN_IDLE    = 4'b0001,
    IN_INT     = 4'b0010,
    IN_STRLEN  = 4'b0100,
    IN_STRBODY = 4'b1000
  } inner_phase_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHR_ZERO) && (b <= CHR_NINE);
  endfunction

  // Key byte at index 0..3 of "info"
  function automatic logic [7:0] info_key_byte(input logic [1:0] idx);
    logic [7:0] k;
    case (idx)
      2'd0:    k = 8'h69;  // 'i'
      2'd1:    k = 8'h6e;  // 'n'
      2'd2:    k = 8'h66;  // 'f'
      default: k = 8'h6f;  // 'o'
    endcase
    return k;
  endfunction

  // acc*10 + digit, saturating at all ones
  function automatic logic [CNT_BITS-1:0] add_digit(input logic [CNT_BITS-1:0] acc,
                                                     input logic [7:0] b);
    logic [CNT_BITS+3:0] wide;
    wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (CNT_BITS+4)'(b[3:0]);
    if (wide[CNT_BITS+3:CNT_BITS] != 4'b0) begin
      return '1;
    end
    return wide[CNT_BITS-1:0];
  endfunction

endpackage

/* design/bivl_in_if.sv */
interface bivl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* design/bivl_out_if.sv */
interface bivl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] value_offset;
  logic [31:0] value_length;

  modport source (output valid, output found, output value_offset, output value_length,
                  input ready);
  modport sink   (input valid, input found, input value_offset, input value_length,
                  output ready);
endinterface

/* design/bencode_info_value_locator.sv */
// The result is registered; valid in the cycle after the last_byte request is accepted.
// Throughput: one byte per cycle while data.ready is high; each byte updates the scan state.
// A byte without last_byte is taken even while a result waits; a last byte waits for it.
// Reset (rst, synchronous) clears the scanner to wait for the opening 'd', drops any result.
// After every last byte the scanner returns to that same reset state.
module bencode_info_value_locator (
  input logic        clk,
  input logic        rst,
  bivl_in_if.sink    data,
  bivl_out_if.source result
);
  import bivl_pkg::*;

`include "bencode_info_value_locator_assert.svh"

  // Scan state
  scan_phase_t             scan_phase, scan_phase_next;
  inner_phase_t            inner_phase, inner_phase_next;
  logic [OFFSET_BITS-1:0]  byte_position, byte_position_next;
  logic [CNT_BITS-1:0]     pending_count, pending_count_next;
  logic [2:0]              key_byte_index, key_byte_index_next;
  logic                    key_matches, key_matches_next;
  logic                    target_value_flag, target_value_flag_next;
  logic [OFFSET_BITS-1:0]  value_start, value_start_next;
  logic [DEPTH_BITS-1:0]   nest_depth, nest_depth_next;
  logic                    outcome_found, outcome_found_next;
  logic [OFFSET_BITS-1:0]  outcome_length, outcome_length_next;

  // Result register
  logic                    res_valid;
  logic                    res_found, res_found_next;
  logic [FIELD_BITS-1:0]   res_offset, res_offset_next;
  logic [FIELD_BITS-1:0]   res_length, res_length_next;

  logic                    in_fire;
  logic [OFFSET_BITS-1:0]  pos_after;
  logic                    do_fail, do_complete, decided, hit;
  logic [7:0]              b;

  assign b          = data.data_byte;
  assign data.ready = !res_valid || result.ready || !data.last_byte;
  assign in_fire    = data.valid && data.ready;
  assign pos_after  = (&byte_position) ? byte_position : byte_position + 1'b1;

  // Per-byte scan update
  always_comb begin
    scan_phase_next        = scan_phase;
    inner_phase_next       = inner_phase;
    byte_position_next     = byte_position;
    pending_count_next     = pending_count;
    key_byte_index_next    = key_byte_index;
    key_matches_next       = key_matches;
    target_value_flag_next = target_value_flag;
    value_start_next       = value_start;
    nest_depth_next        = nest_depth;
    outcome_found_next     = outcome_found;
    outcome_length_next    = outcome_length;
    res_found_next         = 1'b0;
    res_offset_next        = '0;
    res_length_next        = '0;
    do_fail                = 1'b0;
    do_complete            = 1'b0;
    decided                = 1'b0;
    hit                    = 1'b0;

    if (in_fire) begin
      case (scan_phase)
        PH_OPEN: begin
          if (b == CHR_D) scan_phase_next = PH_ENTRY;
          else do_fail = 1'b1;
        end
        PH_ENTRY: begin
          if (is_digit(b)) begin
            pending_count_next = CNT_BITS'(b[3:0]);
            scan_phase_next    = PH_KEYLEN;
          end else begin
            do_fail = 1'b1;
          end
        end
        PH_KEYLEN: begin
          if (is_digit(b)) begin
            pending_count_next = add_digit(pending_count, b);
          end else if (b == CHR_COLON) begin
            key_byte_index_next = '0;
            key_matches_next    = (pending_count == KEY_LEN);
            if (pending_count == '0) begin
              target_value_flag_next = 1'b0;
              scan_phase_next        = PH_VALSTART;
            end else begin
              scan_phase_next = PH_KEYBODY;
            end
          end else begin
            do_fail = 1'b1;
          end
        end
        PH_KEYBODY: begin
          if (!key_byte_index[2] && (b != info_key_byte(key_byte_index[1:0]))) begin
            key_matches_next = 1'b0;
          end
          key_byte_index_next = key_byte_index + 1'b1;
          pending_count_next  = pending_count - 1'b1;
          if (pending_count_next == '0) begin
            target_value_flag_next = key_matches_next;
            scan_phase_next        = PH_VALSTART;
          end
        end
        PH_VALSTART: begin
          value_start_next = byte_position;
          if (b == CHR_I) begin
            scan_phase_next = PH_INT;
          end else if (is_digit(b)) begin
            pending_count_next = CNT_BITS'(b[3:0]);
            scan_phase_next    = PH_STRLEN;
          end else if (b == CHR_L || b == CHR_D) begin
            nest_depth_next  = DEPTH_BITS'(1);
            inner_phase_next = IN_IDLE;
            scan_phase_next  = PH_NEST;
          end else begin
            do_fail = 1'b1;
          end
        end
        PH_INT: begin
          if (b == CHR_E) do_complete = 1'b1;
        end
        PH_STRLEN: begin
          if (is_digit(b)) begin
            pending_count_next = add_digit(pending_count, b);
          end else if (b == CHR_COLON) begin
            if (pending_count == '0) do_complete = 1'b1;
            else scan_phase_next = PH_STRBODY;
          end else begin
            do_fail = 1'b1;
          end
        end
        PH_STRBODY: begin
          pending_count_next = pending_count - 1'b1;
          if (pending_count_next == '0) do_complete = 1'b1;
        end
        PH_NEST: begin
          case (inner_phase)
            IN_IDLE: begin
              if (b == CHR_E) begin
                nest_depth_next = nest_depth - 1'b1;
                if (nest_depth_next == '0) do_complete = 1'b1;
              end else if (b == CHR_L || b == CHR_D) begin
                if (&nest_depth) do_fail = 1'b1;
                else nest_depth_next = nest_depth + 1'b1;
              end else if (is_digit(b)) begin
                pending_count_next = CNT_BITS'(b[3:0]);
                inner_phase_next   = IN_STRLEN;
              end else if (b == CHR_I) begin
                inner_phase_next = IN_INT;
              end else begin
                do_fail = 1'b1;
              end
            end
            IN_INT: begin
              if (b == CHR_E) inner_phase_next = IN_IDLE;
            end
            IN_STRLEN: begin
              if (is_digit(b)) begin
                pending_count_next = add_digit(pending_count, b);
              end else if (b == CHR_COLON) begin
                inner_phase_next = (pending_count == '0) ? IN_IDLE : IN_STRBODY;
              end else begin
                do_fail = 1'b1;
              end
            end
            default: begin
              pending_count_next = pending_count - 1'b1;
              if (pending_count_next == '0) inner_phase_next = IN_IDLE;
            end
          endcase
        end
        default: ;  // decided: later bytes are ignored
      endcase

      // Outcome latch on failure or on completion of a value
      if (do_fail) begin
        scan_phase_next     = PH_DONE;
        outcome_found_next  = 1'b0;
        outcome_length_next = '0;
      end else if (do_complete) begin
        if (target_value_flag) begin
          scan_phase_next     = PH_DONE;
          outcome_found_next  = 1'b1;
          outcome_length_next = pos_after - value_start;
        end else begin
          scan_phase_next = PH_ENTRY;
        end
      end

      byte_position_next = pos_after;

      // End of buffer: form the result, then return to reset state
      if (data.last_byte) begin
        decided = (scan_phase_next == PH_DONE);
        if (decided) begin
          hit = outcome_found_next;
        end else begin
          hit = target_value_flag_next &&
                ((scan_phase_next == PH_INT) ||
                 ((scan_phase_next == PH_NEST) &&
                  ((inner_phase_next == IN_IDLE) || (inner_phase_next == IN_INT))));
        end
        res_found_next = hit;
        if (hit) begin
          res_offset_next = FIELD_BITS'(value_start_next);
          res_length_next = decided ? FIELD_BITS'(outcome_length_next)
                                    : FIELD_BITS'(pos_after - value_start_next);
        end

        scan_phase_next        = PH_OPEN;
        inner_phase_next       = IN_IDLE;
        byte_position_next     = '0;
        pending_count_next     = '0;
        key_byte_index_next    = '0;
        key_matches_next       = 1'b1;
        target_value_flag_next = 1'b0;
        value_start_next       = '0;
        nest_depth_next        = '0;
        outcome_found_next     = 1'b0;
        outcome_length_next    = '0;
      end
    end
  end

  // Scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase        <= PH_OPEN;
      inner_phase       <= IN_IDLE;
      byte_position     <= '0;
      pending_count     <= '0;
      key_byte_index    <= '0;
      key_matches       <= 1'b1;
      target_value_flag <= 1'b0;
      value_start       <= '0;
      nest_depth        <= '0;
      outcome_found     <= 1'b0;
      outcome_length    <= '0;
    end else begin
      scan_phase        <= scan_phase_next;
      inner_phase       <= inner_phase_next;
      byte_position     <= byte_position_next;
      pending_count     <= pending_count_next;
      key_byte_index    <= key_byte_index_next;
      key_matches       <= key_matches_next;
      target_value_flag <= target_value_flag_next;
      value_start       <= value_start_next;
      nest_depth        <= nest_depth_next;
      outcome_found     <= outcome_found_next;
      outcome_length    <= outcome_length_next;
    end
  end

  // Result valid: loaded by a last byte, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_fire && data.last_byte) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire && data.last_byte) begin
      res_found  <= res_found_next;
      res_offset <= res_offset_next;
      res_length <= res_length_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.found        = res_found;
  assign result.value_offset = res_offset;
  assign result.value_length = res_length;

  // Checks
  `BIVL_ASSERT_NEXT(a_restart_after_last, in_fire && data.last_byte,
    scan_phase == PH_OPEN && byte_position == '0 && res_valid,
    "scanner did not restart after last byte")
  `BIVL_ASSERT_NOW(a_no_result_overrun, in_fire && data.last_byte,
    !res_valid || result.ready, "last byte accepted over a pending result")
  `BIVL_ASSERT_NOW(a_nest_depth_live, scan_phase == PH_NEST,
    nest_depth != '0, "nesting depth zero inside a container")
  `BIVL_ASSERT_NOW(a_body_count_live,
    scan_phase == PH_KEYBODY || scan_phase == PH_STRBODY ||
    (scan_phase == PH_NEST && inner_phase == IN_STRBODY),
    pending_count != '0, "body byte count zero while in a body")
  `BIVL_ASSERT_NOW(a_found_only_done, outcome_found,
    scan_phase == PH_DONE, "found latched outside decided state")

endmodule

/* verif/tb_bencode_info_value_locator.sv */
module tb_bencode_info_value_locator;
  timeunit 1ns;
  timeprecision 1ps;

  import bivl_pkg::*;

  typedef struct packed {
    logic                  found;
    logic [FIELD_BITS-1:0] offset;
    logic [FIELD_BITS-1:0] length;
  } locate_result_t;

  localparam int          MAX_SHOWN     = 10;
  localparam int          TOTAL_BYTES   = 1150;
  localparam int          RANDOM_FRAMES = 40;
  localparam logic [63:0] COUNT_CEIL    = (64'd1 << CNT_BITS) - 64'd1;
  localparam logic [31:0] INFO_KEY      = "info";

  logic clk = 1'b0;
  logic rst;

  bivl_in_if  data_if ();
  bivl_out_if result_if ();

  bencode_info_value_locator u_dut (
    .clk   (clk),
    .rst   (rst),
    .data  (data_if),
    .result(result_if)
  );

  always #2 clk = ~clk;

  // Scanner mirror
  scan_phase_t            sc_phase;
  inner_phase_t           sc_inner;
  logic [OFFSET_BITS-1:0] sc_pos;
  logic [CNT_BITS-1:0]    sc_count;
  logic [2:0]             sc_key_idx;
  logic                   sc_key_ok;
  logic                   sc_is_info;
  logic [OFFSET_BITS-1:0] sc_start;
  logic [DEPTH_BITS-1:0]  sc_depth;
  logic                   sc_decided;
  logic                   sc_found;
  logic [OFFSET_BITS-1:0] sc_len;

  locate_result_t expected_locs[$];
  logic [7:0]     frame[$];

  int   fail_count    = 0;
  int   results_seen  = 0;
  int   bytes_sent    = 0;
  int   burst_left    = 0;
  logic pace_on       = 1'b1;
  logic valid_high    = 1'b0;
  logic [5:0]  stall_tick = '0;
  logic [15:0] stall_pat  = 16'hffff;

  function automatic logic is_numeral(input logic [7:0] b);
    return b >= CHR_ZERO && b <= CHR_NINE;
  endfunction

  // Decimal accumulate, pinned at all ones
  function automatic logic [CNT_BITS-1:0] grow_count(input logic [CNT_BITS-1:0] acc,
                                                     input logic [7:0] b);
    logic [63:0] wide;
    wide = 64'(acc) * 64'd10 + 64'(b[3:0]);
    return (wide > COUNT_CEIL) ? COUNT_CEIL[CNT_BITS-1:0] : wide[CNT_BITS-1:0];
  endfunction

  function automatic logic [OFFSET_BITS-1:0] pos_after();
    return (sc_pos == '1) ? sc_pos : sc_pos + 1'b1;
  endfunction

  function automatic void scan_reset();
    sc_phase   = PH_OPEN;
    sc_inner   = IN_IDLE;
    sc_pos     = '0;
    sc_count   = '0;
    sc_key_idx = '0;
    sc_key_ok  = 1'b1;
    sc_is_info = 1'b0;
    sc_start   = '0;
    sc_depth   = '0;
    sc_decided = 1'b0;
    sc_found   = 1'b0;
    sc_len     = '0;
  endfunction

  function automatic void latch_miss();
    sc_decided = 1'b1;
    sc_found   = 1'b0;
    sc_len     = '0;
    sc_phase   = PH_DONE;
  endfunction

  // A top-level value just closed: latch it if it belongs to "info"
  function automatic void finish_value();
    if (sc_is_info) begin
      sc_decided = 1'b1;
      sc_found   = 1'b1;
      sc_len     = pos_after() - sc_start;
      sc_phase   = PH_DONE;
    end else begin
      sc_phase = PH_ENTRY;
    end
  endfunction

  // Element walk inside a list or dictionary value
  function automatic void nest_byte(input logic [7:0] b);
    case (sc_inner)
      IN_IDLE: begin
        if (b == CHR_E) begin
          sc_depth = sc_depth - 1'b1;
          if (sc_depth == '0) finish_value();
        end else if (b == CHR_L || b == CHR_D) begin
          if (sc_depth == '1) latch_miss();
          else sc_depth = sc_depth + 1'b1;
        end else if (is_numeral(b)) begin
          sc_count = CNT_BITS'(b[3:0]);
          sc_inner = IN_STRLEN;
        end else if (b == CHR_I) begin
          sc_inner = IN_INT;
        end else begin
          latch_miss();
        end
      end
      IN_INT: begin
        if (b == CHR_E) sc_inner = IN_IDLE;
      end
      IN_STRLEN: begin
        if (is_numeral(b)) sc_count = grow_count(sc_count, b);
        else if (b == CHR_COLON) sc_inner = (sc_count == '0) ? IN_IDLE : IN_STRBODY;
        else latch_miss();
      end
      default: begin
        sc_count = sc_count - 1'b1;
        if (sc_count == '0) sc_inner = IN_IDLE;
      end
    endcase
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    case (sc_phase)
      PH_OPEN: begin
        if (b == CHR_D) sc_phase = PH_ENTRY;
        else latch_miss();
      end
      PH_ENTRY: begin
        if (is_numeral(b)) begin
          sc_count = CNT_BITS'(b[3:0]);
          sc_phase = PH_KEYLEN;
        end else begin
          latch_miss();
        end
      end
      PH_KEYLEN: begin
        if (is_numeral(b)) begin
          sc_count = grow_count(sc_count, b);
        end else if (b == CHR_COLON) begin
          sc_key_idx = '0;
          sc_key_ok  = (sc_count == KEY_LEN);
          if (sc_count == '0) begin
            sc_is_info = 1'b0;
            sc_phase   = PH_VALSTART;
          end else begin
            sc_phase = PH_KEYBODY;
          end
        end else begin
          latch_miss();
        end
      end
      PH_KEYBODY: begin
        if (sc_key_idx < 3'd4 && b != INFO_KEY[8*(3-int'(sc_key_idx)) +: 8]) sc_key_ok = 1'b0;
        sc_key_idx = sc_key_idx + 1'b1;
        sc_count   = sc_count - 1'b1;
        if (sc_count == '0) begin
          sc_is_info = sc_key_ok;
          sc_phase   = PH_VALSTART;
        end
      end
      PH_VALSTART: begin
        sc_start = sc_pos;
        if (b == CHR_I) begin
          sc_phase = PH_INT;
        end else if (is_numeral(b)) begin
          sc_count = CNT_BITS'(b[3:0]);
          sc_phase = PH_STRLEN;
        end else if (b == CHR_L || b == CHR_D) begin
          sc_depth = DEPTH_BITS'(1);
          sc_inner = IN_IDLE;
          sc_phase = PH_NEST;
        end else begin
          latch_miss();
        end
      end
      PH_INT: begin
        if (b == CHR_E) finish_value();
      end
      PH_STRLEN: begin
        if (is_numeral(b)) begin
          sc_count = grow_count(sc_count, b);
        end else if (b == CHR_COLON) begin
          if (sc_count == '0) finish_value();
          else sc_phase = PH_STRBODY;
        end else begin
          latch_miss();
        end
      end
      PH_STRBODY: begin
        sc_count = sc_count - 1'b1;
        if (sc_count == '0) finish_value();
      end
      PH_NEST: nest_byte(b);
      default: ;
    endcase
  endfunction

  // One accepted request; the last byte of a buffer yields the expected locate result
  function automatic void locate_step(input logic [7:0] b, input logic last);
    locate_result_t res;
    bytes_sent++;
    if (!sc_decided) begin
      scan_byte(b);
    end
    sc_pos = pos_after();
    if (last) begin
      res = '0;
      if (sc_decided) begin
        if (sc_found) begin
          res.found  = 1'b1;
          res.offset = FIELD_BITS'(sc_start);
          res.length = FIELD_BITS'(sc_len);
        end
      end else if (sc_is_info && (sc_phase == PH_INT ||
                                  (sc_phase == PH_NEST &&
                                   (sc_inner == IN_IDLE || sc_inner == IN_INT)))) begin
        // value cut off by the end of the buffer still counts
        res.found  = 1'b1;
        res.offset = FIELD_BITS'(sc_start);
        res.length = FIELD_BITS'(sc_pos - sc_start);
      end
      expected_locs.push_back(res);
      scan_reset();
    end
  endfunction

  function automatic void check_result();
    locate_result_t want;
    if (expected_locs.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_SHOWN)
        $display("unexpected result: found=%0b offset=%0d length=%0d",
                 result_if.found, result_if.value_offset, result_if.value_length);
      return;
    end
    want = expected_locs.pop_front();
    if (result_if.found !== want.found || result_if.value_offset !== want.offset ||
        result_if.value_length !== want.length) begin
      fail_count++;
      if (fail_count <= MAX_SHOWN)
        $display({"result %0d: expected found=%0b offset=%0d length=%0d,",
                  " got found=%0b offset=%0d length=%0d"},
                 results_seen, want.found, want.offset, want.length,
                 result_if.found, result_if.value_offset, result_if.value_length);
    end
    results_seen++;
  endfunction

  function automatic logic [15:0] next_pattern();
    logic [15:0] p;
    case ($urandom_range(0, 3))
      0:       p = 16'hffff;
      1:       p = 16'($urandom);
      2:       p = 16'($urandom) & 16'($urandom);
      default: p = 16'($urandom) | 16'($urandom);
    endcase
    return (p == '0) ? 16'h0001 : p;
  endfunction

  // Result side: check each accepted result, stall on a rotating pattern
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) check_result();
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick == '0) stall_pat <= next_pattern();
    else stall_pat <= {stall_pat[0], stall_pat[15:1]};
    result_if.ready <= stall_pat[0];
  end

  // Sender bursts with random gaps between them
  task automatic pace();
    if (!pace_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    data_if.valid <= 1'b0;
    valid_high = 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    data_if.valid     <= 1'b1;
    data_if.data_byte <= b;
    data_if.last_byte <= last;
    valid_high = 1'b1;
    @(posedge clk);
    while (!data_if.ready) @(posedge clk);
    locate_step(b, last);
    pace();
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
  endtask

  // Hold off the sender until every pending result has been taken
  task automatic wait_results_done();
    if (valid_high) begin
      data_if.valid <= 1'b0;
      valid_high = 1'b0;
      @(posedge clk);
    end
    while (expected_locs.size() != 0) @(posedge clk);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endtask

  task automatic run_case(input string s);
    frame.delete();
    put_str(s);
    send_frame();
  endtask

  task automatic put_int();
    frame.push_back(CHR_I);
    if ($urandom_range(0, 3) == 0) put_str("-");
    put_str($sformatf("%0d", $urandom_range(0, 99999)));
    frame.push_back(CHR_E);
  endtask

  task automatic put_string();
    int len;
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
    if ($urandom_range(0, 7) == 0) frame.push_back(CHR_ZERO);
    put_str($sformatf("%0d:", len));
    repeat (len) frame.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: put_str("4:info");
      4:          put_str("04:info");
      5:          put_str("4:infp");
      6:          put_str("5:infoo");
      7:          put_str("3:inf");
      default:    put_string();
    endcase
  endtask

  // Any value; containers are walked flat with an open count
  task automatic put_value();
    int shape;
    int open;
    int budget;
    int pick;
    shape = $urandom_range(0, 3);
    if (shape == 0) begin
      put_int();
    end else if (shape == 1) begin
      put_string();
    end else begin
      frame.push_back(shape == 2 ? CHR_L : CHR_D);
      open   = 1;
      budget = $urandom_range(0, 8);
      while (open > 0) begin
        pick = $urandom_range(0, 9);
        if (budget == 0 || pick < 2) begin
          frame.push_back(CHR_E);
          open--;
        end else begin
          budget--;
          if (pick < 4 && open < 6) begin
            frame.push_back(pick == 2 ? CHR_L : CHR_D);
            open++;
          end else if (pick < 7) begin
            put_int();
          end else begin
            put_string();
          end
        end
      end
    end
  endtask

  task automatic build_random_frame();
    int style;
    int cut;
    logic [7:0] syntax_bytes[6];
    syntax_bytes = '{CHR_D, CHR_E, CHR_I, CHR_L, CHR_COLON, CHR_ZERO};
    frame.delete();
    style = $urandom_range(0, 99);
    // pure noise
    if (style < 10) begin
      repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom_range(0, 255)));
      return;
    end
    frame.push_back(CHR_D);
    repeat ($urandom_range(0, 4)) begin
      put_key();
      put_value();
    end
    frame.push_back(CHR_E);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
    // broken sequences
    if (style >= 75) begin
      case ($urandom_range(0, 2))
        0: begin
          cut = $urandom_range(1, frame.size() - 1);
          while (frame.size() > cut) void'(frame.pop_back());
        end
        1:       frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
        default: frame[$urandom_range(0, frame.size() - 1)] = syntax_bytes[$urandom_range(0, 5)];
      endcase
    end
  endtask

  task automatic test_well_formed();
    run_case("d4:infoi42ee");
    run_case("d3:abc3:xyz4:info5:helloe");
    run_case("d4:infold1:ai-1e2:bbl3:xyzee4:spami0ee");
    run_case("d4:info0:e");
    run_case("d4:infolee");
    run_case("d04:infoi7ee");
    run_case("d0:i1e4:infodee");
    run_case("d4:infp1:x5:infoxi1e4:info4:die:e");
    // bytes after the located value are ignored
    frame.delete();
    put_str("d4:infoi1ee");
    frame.push_back(8'h00);
    frame.push_back(8'hff);
    send_frame();
    wait_results_done();
  endtask

  task automatic test_malformed();
    run_case("l4:infoi1ee");
    run_case("dx:infoi1ee");
    run_case("d4xinfo");
    run_case("d4:infoxe");
    run_case("de");
    run_case("d4:infolxe");
    run_case("d4:info12a");
    wait_results_done();
  endtask

  task automatic test_truncation();
    run_case("d4:in");
    run_case("d4:info12");
    run_case("d4:info5:ab");
    run_case("d4:info");
    run_case("d4:infoi12");
    run_case("d4:infoli1e");
    run_case("d4:infoli12");
    run_case("d4:infol3:ab");
    run_case("d4:infol3");
    run_case("d");
    frame.delete();
    frame.push_back(8'hff);
    send_frame();
    wait_results_done();
  endtask

  task automatic test_saturation();
    run_case("d99999999999:info");
    run_case("d4:info99999999999999:xy");
    run_case("d4:infol88888888888:ab");
    wait_results_done();
  endtask

  // Random buffers until the overall byte budget is spent and RANDOM_FRAMES buffers are sent
  task automatic test_random();
    int frames_sent;
    frames_sent = 0;
    while (bytes_sent < TOTAL_BYTES || frames_sent < RANDOM_FRAMES) begin
      build_random_frame();
      send_frame();
      frames_sent++;
      if ($urandom_range(0, 15) == 0) wait_results_done();
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    data_if.valid       <= 1'b0;
    data_if.data_byte   <= '0;
    data_if.last_byte   <= 1'b0;
    scan_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_well_formed();
    test_malformed();
    test_truncation();
    test_saturation();
    test_random();

    wait_results_done();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS bencode_info_value_locator");
    end else begin
      $display("FAIL bencode_info_value_locator");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("FAIL bencode_info_value_locator");
    $finish;
  end

endmodule
